### rtl/window_pixel_clip_alpha_blit_core_macros.svh
// Assertion helpers shared by the blit core files.
`ifndef WINDOW_PIXEL_CLIP_ALPHA_BLIT_CORE_MACROS_SVH
`define WINDOW_PIXEL_CLIP_ALPHA_BLIT_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, off during reset
`define WPCAB_ASSERT(label, ant, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("wpcab assertion failed");

// next-cycle implication, off during reset
`define WPCAB_ASSERT_NEXT(label, ant, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("wpcab assertion failed");

`else

`define WPCAB_ASSERT(label, ant, cons)
`define WPCAB_ASSERT_NEXT(label, ant, cons)

`endif

`endif

### rtl/wpcab_pkg.sv
`default_nettype none
package wpcab_pkg;

   localparam int MaxDimension = 4096;
   localparam int DimWidth     = 13;
   localparam int PosWidth     = 12;
   localparam int IndexWidth   = 24;
   localparam int PixelWidth   = 32;
   localparam int SumWidth     = 16;
   localparam int RegIdxWidth  = 3;

   localparam logic [RegIdxWidth-1:0] RegScreenWidth  = 3'd0;
   localparam logic [RegIdxWidth-1:0] RegScreenHeight = 3'd1;
   localparam logic [RegIdxWidth-1:0] RegWindowX      = 3'd2;
   localparam logic [RegIdxWidth-1:0] RegWindowY      = 3'd3;
   localparam logic [RegIdxWidth-1:0] RegTransparent  = 3'd4;

   localparam logic [DimWidth-1:0] ResetScreenWidth  = 13'd640;
   localparam logic [DimWidth-1:0] ResetScreenHeight = 13'd480;

   localparam logic [7:0] AlphaFull = 8'hFF;
   localparam logic [7:0] AlphaNone = 8'h00;

   // stage load enables, one per pipeline register rank
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } wpcab_stage_type;

   typedef struct packed {
      logic [DimWidth-1:0]        disp_width;
      logic [DimWidth-1:0]        disp_height;
      logic signed [DimWidth-1:0] window_x;
      logic signed [DimWidth-1:0] window_y;
      logic                       transparent_mode;
   } wpcab_cfg_type;

   function automatic logic [DimWidth-1:0] clamp_dim(input logic [DimWidth-1:0] v);
      logic [DimWidth-1:0] lim;
      lim = DimWidth'(MaxDimension);
      return (v > lim) ? lim : v;
   endfunction

   // exact floor(s/255) for s up to 255*255
   function automatic logic [7:0] div255(input logic [SumWidth-1:0] s);
      logic [SumWidth:0] t;
      t = {1'b0, s} + (SumWidth+1)'(1) + {9'b0, s[15:8]};
      return t[15:8];
   endfunction

endpackage
`default_nettype wire

### rtl/wpcab_pos.sv
`default_nettype none
`include "window_pixel_clip_alpha_blit_core_macros.svh"
module wpcab_pos
   import wpcab_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire wpcab_stage_type         stage,
   input  wire wpcab_cfg_type           cfg,
   input  wire logic [PosWidth-1:0]     column,
   input  wire logic [PosWidth-1:0]     row,
   output logic                         on_screen,
   output logic [IndexWidth-1:0]        row_base,
   output logic [PosWidth-1:0]          screen_x
);

   logic signed [DimWidth:0] sx_in;
   logic signed [DimWidth:0] sy_in;
   logic [DimWidth-1:0]      sw_in;
   logic [DimWidth-1:0]      sh_in;
   logic                     on1_in;
   logic                     on1_ff;
   logic [PosWidth-1:0]      sx1_ff;
   logic [PosWidth-1:0]      sy1_ff;
   logic [DimWidth-1:0]      sw1_ff;
   logic [IndexWidth:0]      prod_in;
   logic                     on2_ff;
   logic [IndexWidth-1:0]    prod2_ff;
   logic [PosWidth-1:0]      sx2_ff;

   always_comb begin
      sw_in  = clamp_dim(cfg.disp_width);
      sh_in  = clamp_dim(cfg.disp_height);
      sx_in  = $signed({cfg.window_x[DimWidth-1], cfg.window_x})
               + $signed({2'b00, column});
      sy_in  = $signed({cfg.window_y[DimWidth-1], cfg.window_y})
               + $signed({2'b00, row});
      on1_in = !sx_in[DimWidth] && (sx_in[DimWidth-1:0] < sw_in)
               && !sy_in[DimWidth] && (sy_in[DimWidth-1:0] < sh_in);
      prod_in = (IndexWidth+1)'(sy1_ff) * (IndexWidth+1)'(sw1_ff);
   end

   always_ff @(posedge clock) begin
      if (stage.load1) begin
         on1_ff <= on1_in;
         sx1_ff <= sx_in[PosWidth-1:0];
         sy1_ff <= sy_in[PosWidth-1:0];
         sw1_ff <= sw_in;
      end
      if (stage.load2) begin
         on2_ff   <= on1_ff;
         prod2_ff <= prod_in[IndexWidth-1:0];
         sx2_ff   <= sx1_ff;
      end
   end

   assign on_screen = on2_ff;
   assign row_base  = prod2_ff;
   assign screen_x  = sx2_ff;

   // an on-screen position always lies below the clamped width
   `WPCAB_ASSERT(a_pos_x_in_range, stage.load1 && on1_in,
                 {1'b0, sx_in[PosWidth-1:0]} < sw_in)

endmodule
`default_nettype wire

### rtl/wpcab_mix.sv
`default_nettype none
module wpcab_mix
   import wpcab_pkg::*;
(
   input  wire logic                    clock,
   input  wire wpcab_stage_type         stage,
   input  wire logic                    transparent_mode,
   input  wire logic [PixelWidth-1:0]   fg,
   input  wire logic [PixelWidth-1:0]   bg,
   output logic                         pixel_write,
   output logic [PixelWidth-1:0]        pixel
);

   logic [7:0]          alpha;
   logic [SumWidth-1:0] sum_in [3];
   logic                pass_in;
   logic                write_in;
   logic [SumWidth-1:0] sum1_ff [3];
   logic [PixelWidth-1:0] fg1_ff;
   logic                pass1_ff;
   logic                write1_ff;
   logic [PixelWidth-1:0] pix_in;
   logic [PixelWidth-1:0] pix2_ff;
   logic                write2_ff;

   always_comb begin
      alpha = fg[31:24];
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = SumWidth'(fg[8*c +: 8]) * SumWidth'(alpha)
                   + SumWidth'(bg[8*c +: 8]) * SumWidth'(AlphaFull - alpha);
      end
      pass_in  = !transparent_mode || (alpha == AlphaFull);
      write_in = !transparent_mode || (alpha != AlphaNone);
      pix_in   = pass1_ff ? fg1_ff
                 : {AlphaFull, div255(sum1_ff[2]), div255(sum1_ff[1]), div255(sum1_ff[0])};
   end

   always_ff @(posedge clock) begin
      if (stage.load1) begin
         for (int c = 0; c < 3; c++) begin
            sum1_ff[c] <= sum_in[c];
         end
         fg1_ff    <= fg;
         pass1_ff  <= pass_in;
         write1_ff <= write_in;
      end
      if (stage.load2) begin
         pix2_ff   <= pix_in;
         write2_ff <= write1_ff;
      end
   end

   assign pixel_write = write2_ff;
   assign pixel       = pix2_ff;

endmodule
`default_nettype wire

### rtl/window_pixel_clip_alpha_blit_core.sv
// Channel   Ports                                     Direction
// req       req_valid/req_ready, pixel, position      in, one pixel word
// rsp       rsp_valid/rsp_ready, write, index, pixel  out, one result word
// csr       csr_valid/csr_ready, csr_index, csr_wdata in, register write
//
// Three register stages: position add and clip with channel products, then
// row times pitch with the divide by 255, then index add and output select.
// One word per clock while rsp is ready; an accepted word passes each
// stage register in order, and the last one drives rsp_valid.
// Each stage loads when empty or when the stage after it moves, so a stall
// on rsp backs up through the stages without loss or repeat.
// Reset is synchronous; it clears the valid bits and loads register defaults.
`default_nettype none
`include "window_pixel_clip_alpha_blit_core_macros.svh"
module window_pixel_clip_alpha_blit_core
   import wpcab_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [PixelWidth-1:0]   req_window_pixel,
   input  wire logic [PixelWidth-1:0]   req_dest_pixel,
   input  wire logic [PosWidth-1:0]     req_column,
   input  wire logic [PosWidth-1:0]     req_row,
   input  wire logic                    req_last_in_window,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_write_enable,
   output logic [IndexWidth-1:0]        rsp_dest_index,
   output logic [PixelWidth-1:0]        rsp_out_pixel,
   output logic                         rsp_last_out,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [RegIdxWidth-1:0]  csr_index,
   input  wire logic [DimWidth-1:0]     csr_wdata
);

   wpcab_cfg_type   cfg_ff;
   wpcab_cfg_type   cfg_in;
   wpcab_stage_type stage;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic last1_ff, last2_ff, last3_ff;
   logic on2;
   logic [IndexWidth-1:0] row_base2;
   logic [PosWidth-1:0]   sx2;
   logic                  pix_write2;
   logic [PixelWidth-1:0] pix2;
   logic                  we_in;
   logic                  we3_ff;
   logic [IndexWidth-1:0] idx_in;
   logic [IndexWidth-1:0] idx3_ff;
   logic [PixelWidth-1:0] pix_in;
   logic [PixelWidth-1:0] pix3_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            RegScreenWidth:  cfg_in.disp_width       = csr_wdata;
            RegScreenHeight: cfg_in.disp_height      = csr_wdata;
            RegWindowX:      cfg_in.window_x         = $signed(csr_wdata);
            RegWindowY:      cfg_in.window_y         = $signed(csr_wdata);
            RegTransparent:  cfg_in.transparent_mode = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disp_width       <= ResetScreenWidth;
         cfg_ff.disp_height      <= ResetScreenHeight;
         cfg_ff.window_x         <= '0;
         cfg_ff.window_y         <= '0;
         cfg_ff.transparent_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ready ripples back from the output register
   always_comb begin
      rdy3 = !v3_ff || rsp_ready;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      stage.load1 = rdy1;
      stage.load2 = rdy2;
      stage.load3 = rdy3;
   end

   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   wpcab_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .cfg       (cfg_ff),
      .column    (req_column),
      .row       (req_row),
      .on_screen (on2),
      .row_base  (row_base2),
      .screen_x  (sx2)
   );

   wpcab_mix u_mix (
      .clock            (clock),
      .stage            (stage),
      .transparent_mode (cfg_ff.transparent_mode),
      .fg               (req_window_pixel),
      .bg               (req_dest_pixel),
      .pixel_write      (pix_write2),
      .pixel            (pix2)
   );

   always_comb begin
      we_in  = on2 && pix_write2;
      idx_in = we_in ? (row_base2 + IndexWidth'(sx2)) : '0;
      pix_in = we_in ? pix2 : '0;
   end

   always_ff @(posedge clock) begin
      if (stage.load1) last1_ff <= req_last_in_window;
      if (stage.load2) last2_ff <= last1_ff;
      if (stage.load3) begin
         last3_ff <= last2_ff;
         we3_ff   <= we_in;
         idx3_ff  <= idx_in;
         pix3_ff  <= pix_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_write_enable = we3_ff;
   assign rsp_dest_index   = idx3_ff;
   assign rsp_out_pixel    = pix3_ff;
   assign rsp_last_out     = last3_ff;

   `WPCAB_ASSERT(a_no_write_zero, rsp_valid && !rsp_write_enable,
                 rsp_dest_index == '0 && rsp_out_pixel == '0)
   `WPCAB_ASSERT(a_transparent_opaque_alpha,
                 rsp_valid && rsp_write_enable && cfg_ff.transparent_mode,
                 rsp_out_pixel[31:24] == AlphaFull)
   `WPCAB_ASSERT_NEXT(a_mid_stage_holds, v2_ff && !rdy2, v2_ff)
   `WPCAB_ASSERT_NEXT(a_accept_fills_stage1, req_valid && req_ready, v1_ff)

endmodule
`default_nettype wire

### tb/wpcab_blit_checker.sv
`timescale 1ns / 1ps
module wpcab_blit_checker
   import wpcab_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_ready,
   input  wire logic [PixelWidth-1:0]   req_window_pixel,
   input  wire logic [PixelWidth-1:0]   req_dest_pixel,
   input  wire logic [PosWidth-1:0]     req_column,
   input  wire logic [PosWidth-1:0]     req_row,
   input  wire logic                    req_last_in_window,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic                    rsp_write_enable,
   input  wire logic [IndexWidth-1:0]   rsp_dest_index,
   input  wire logic [PixelWidth-1:0]   rsp_out_pixel,
   input  wire logic                    rsp_last_out,
   input  wire logic                    csr_valid,
   input  wire logic                    csr_ready,
   input  wire logic [RegIdxWidth-1:0]  csr_index,
   input  wire logic [DimWidth-1:0]     csr_wdata,
   output int unsigned                  mismatches,
   output int unsigned                  words_due
);

   typedef struct packed {
      logic                  write;
      logic [IndexWidth-1:0] index;
      logic [PixelWidth-1:0] pixel;
      logic                  last;
   } blit_word_type;

   wpcab_cfg_type screen_cfg;
   blit_word_type pending_blits[$];

   initial begin
      mismatches = 0;
      words_due  = 0;
   end

   function automatic logic [7:0] blend_channel(input int fg, input int bg, input int alpha);
      return 8'((fg * alpha + bg * (255 - alpha)) / 255);
   endfunction

   function automatic blit_word_type predict_blit(input logic [PixelWidth-1:0] fg,
                                                  input logic [PixelWidth-1:0] bg,
                                                  input logic [PosWidth-1:0] col,
                                                  input logic [PosWidth-1:0] row,
                                                  input logic last);
      blit_word_type w;
      int sw, sh, sx, sy, alpha;
      w = '0;
      w.last = last;
      // sizes past the maximum act as the maximum
      sw = (screen_cfg.disp_width > MaxDimension) ? MaxDimension
                                                  : int'(screen_cfg.disp_width);
      sh = (screen_cfg.disp_height > MaxDimension) ? MaxDimension
                                                   : int'(screen_cfg.disp_height);
      sx = int'($signed(screen_cfg.window_x)) + int'(col);
      sy = int'($signed(screen_cfg.window_y)) + int'(row);
      if (sx >= 0 && sx < sw && sy >= 0 && sy < sh) begin
         alpha = int'(fg[31:24]);
         if (!screen_cfg.transparent_mode || fg[31:24] == AlphaFull) begin
            w.write = 1'b1;
            w.pixel = fg;
         end else if (fg[31:24] != AlphaNone) begin
            w.write = 1'b1;
            w.pixel = {AlphaFull,
                       blend_channel(int'(fg[23:16]), int'(bg[23:16]), alpha),
                       blend_channel(int'(fg[15:8]), int'(bg[15:8]), alpha),
                       blend_channel(int'(fg[7:0]), int'(bg[7:0]), alpha)};
         end
         if (w.write)
            w.index = IndexWidth'(sy * sw + sx);
      end
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      blit_word_type want;
      if (reset) begin
         screen_cfg.disp_width       = ResetScreenWidth;
         screen_cfg.disp_height      = ResetScreenHeight;
         screen_cfg.window_x         = '0;
         screen_cfg.window_y         = '0;
         screen_cfg.transparent_mode = 1'b0;
         pending_blits.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_blits.size() == 0) begin
               report_mismatch($sformatf("result word with none pending, index %h pixel %h",
                                         rsp_dest_index, rsp_out_pixel));
            end else begin
               want = pending_blits.pop_front();
               if (rsp_write_enable !== want.write)
                  report_mismatch($sformatf("write_enable want %b got %b",
                                            want.write, rsp_write_enable));
               if (rsp_dest_index !== want.index)
                  report_mismatch($sformatf("dest_index want %h got %h",
                                            want.index, rsp_dest_index));
               if (rsp_out_pixel !== want.pixel)
                  report_mismatch($sformatf("out_pixel want %h got %h",
                                            want.pixel, rsp_out_pixel));
               if (rsp_last_out !== want.last)
                  report_mismatch($sformatf("last_out want %b got %b",
                                            want.last, rsp_last_out));
            end
         end
         // a word taken on the same edge as a register write sees the old setting
         if (req_valid && req_ready)
            pending_blits.push_back(predict_blit(req_window_pixel, req_dest_pixel,
                                                 req_column, req_row, req_last_in_window));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegScreenWidth:  screen_cfg.disp_width       = csr_wdata;
               RegScreenHeight: screen_cfg.disp_height      = csr_wdata;
               RegWindowX:      screen_cfg.window_x         = csr_wdata;
               RegWindowY:      screen_cfg.window_y         = csr_wdata;
               RegTransparent:  screen_cfg.transparent_mode = csr_wdata[0];
               default: ;
            endcase
         end
      end
      words_due = pending_blits.size();
   end

endmodule

### tb/tb_window_pixel_clip_alpha_blit_core.sv
`timescale 1ns / 1ps
module tb_window_pixel_clip_alpha_blit_core;
   import wpcab_pkg::*;

   // index with no register behind it; writes must be ignored
   localparam logic [RegIdxWidth-1:0] RegSpare = 3'd7;
   localparam int Phases      = 7;
   localparam int PhaseWords  = 250;
   localparam int DrainCycles = 4;
   localparam int TailCycles  = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [PixelWidth-1:0]  req_window_pixel;
   logic [PixelWidth-1:0]  req_dest_pixel;
   logic [PosWidth-1:0]    req_column;
   logic [PosWidth-1:0]    req_row;
   logic                   req_last_in_window;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_write_enable;
   logic [IndexWidth-1:0]  rsp_dest_index;
   logic [PixelWidth-1:0]  rsp_out_pixel;
   logic                   rsp_last_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [RegIdxWidth-1:0] csr_index;
   logic [DimWidth-1:0]    csr_wdata;
   int unsigned            mismatches;
   int unsigned            words_due;

   bit                     steady;
   logic [DimWidth-1:0]    cfg_width;
   logic [DimWidth-1:0]    cfg_height;
   logic [DimWidth-1:0]    cfg_x;
   logic [DimWidth-1:0]    cfg_y;

   window_pixel_clip_alpha_blit_core dut (.*);
   wpcab_blit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // sink side: random stall bursts, long ready stretches, none at the end
   initial begin
      int run;
      logic level;
      rsp_ready = 1'b0;
      forever begin
         level = steady || ($urandom_range(0, 2) != 0);
         run = (level && $urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 15);
         repeat (run) begin
            @(negedge clock);
            rsp_ready <= level || steady;
         end
      end
   end

   task automatic req_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_pixel(input logic [PixelWidth-1:0] fg, input logic [PixelWidth-1:0] bg,
                             input logic [PosWidth-1:0] col, input logic [PosWidth-1:0] row,
                             input logic last);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_window_pixel   <= fg;
      req_dest_pixel     <= bg;
      req_column         <= col;
      req_row            <= row;
      req_last_in_window <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [RegIdxWidth-1:0] idx, input logic [DimWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_idle(1);
      do @(negedge clock); while (words_due != 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_screen(input logic [DimWidth-1:0] w, input logic [DimWidth-1:0] h,
                             input logic [DimWidth-1:0] x, input logic [DimWidth-1:0] y,
                             input logic transparent);
      wait_idle();
      cfg_width  = w;
      cfg_height = h;
      cfg_x      = x;
      cfg_y      = y;
      write_reg(RegScreenWidth, w);
      write_reg(RegScreenHeight, h);
      write_reg(RegWindowX, x);
      write_reg(RegWindowY, y);
      write_reg(RegTransparent, {{(DimWidth-1){1'b0}}, transparent});
   endtask

   // mostly lands within one pixel of the visible area, else anywhere
   function automatic logic [PosWidth-1:0] pick_coord(input logic [DimWidth-1:0] origin,
                                                      input logic [DimWidth-1:0] dim);
      int span, target;
      span = (dim > MaxDimension) ? MaxDimension : int'(dim);
      if ($urandom_range(0, 3) == 0)
         return PosWidth'($urandom);
      target = int'($urandom_range(0, span + 1)) - 1 - int'($signed(origin));
      if (target < 0 || target > 4095)
         return PosWidth'($urandom);
      return PosWidth'(target);
   endfunction

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 5))
         0:       return AlphaNone;
         1:       return AlphaFull;
         2:       return 8'd1;
         3:       return 8'd254;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [DimWidth-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'd8191;
         4:       return DimWidth'($urandom_range(4097, 8191));
         5, 6:    return DimWidth'($urandom_range(1, 64));
         default: return DimWidth'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [DimWidth-1:0] pick_origin();
      case ($urandom_range(0, 7))
         0:       return 13'h1000;
         1:       return 13'h0FFF;
         2, 3, 4: return DimWidth'($urandom_range(0, 128)) - 13'd64;
         default: return DimWidth'($urandom);
      endcase
   endfunction

   initial begin
      int p, n;
      bit bursty;
      logic [7:0] alpha;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_window_pixel   = '0;
      req_dest_pixel     = '0;
      req_column         = '0;
      req_row            = '0;
      req_last_in_window = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = RegScreenWidth;
      csr_wdata          = '0;
      steady             = 1'b0;
      cfg_width          = ResetScreenWidth;
      cfg_height         = ResetScreenHeight;
      cfg_x              = '0;
      cfg_y              = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: 640x480 at the origin, opaque, alpha ignored
      send_pixel(32'h0012_3456, 32'hFFFF_FFFF, 0, 0, 1'b0);
      send_pixel(32'h80AB_CDEF, 32'h0000_0000, 639, 479, 1'b0);
      send_pixel(32'hFF00_00FF, 32'h0000_0000, 640, 0, 1'b0);
      send_pixel(32'h0101_0101, 32'h0000_0000, 0, 480, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF, 12'hFFF, 1'b1);

      // origin one column left of the screen, per-pixel alpha
      set_screen(13'd640, 13'd480, 13'h1FFF, 13'd0, 1'b1);
      send_pixel(32'hFF12_3456, 32'h0000_0000, 0, 5, 1'b0);
      send_pixel(32'h0012_3456, 32'h00FF_FFFF, 1, 5, 1'b0);
      send_pixel(32'hFF12_3456, 32'h0000_0000, 2, 5, 1'b0);
      send_pixel(32'h80FF_0000, 32'hFF00_FFFF, 3, 5, 1'b0);
      send_pixel(32'h01FF_FFFF, 32'h0000_0000, 4, 5, 1'b0);
      send_pixel(32'hFE00_0000, 32'h00FF_FFFF, 5, 5, 1'b0);
      send_pixel(32'h7FAA_55C3, 32'h3C5A_A5FF, 640, 479, 1'b1);
      wait_idle();
      write_reg(RegSpare, 13'h1FFF);

      // oversize screen clamps to the maximum; last index of the buffer
      set_screen(13'd8191, 13'd8191, 13'd0, 13'd0, 1'b1);
      send_pixel(32'hFF5A_C3E1, 32'h0000_0000, 12'hFFF, 12'hFFF, 1'b0);
      send_pixel(32'h40FF_80FF, 32'hFF00_7F00, 0, 12'hFFF, 1'b1);

      // zero-size screen writes nothing
      set_screen(13'd0, 13'd0, 13'd0, 13'd0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 1'b1);

      // most negative origin never reaches the screen
      set_screen(13'd1, 13'd1, 13'h1000, 13'h1000, 1'b0);
      send_pixel(32'h00C3_3C96, 32'h0000_0000, 12'hFFF, 12'hFFF, 1'b0);

      // one column wide, origin at the bottom row
      set_screen(13'd1, 13'd4096, 13'd0, 13'h0FFF, 1'b0);
      send_pixel(32'h1234_5678, 32'h8765_4321, 0, 0, 1'b0);
      send_pixel(32'h1234_5678, 32'h8765_4321, 1, 0, 1'b1);

      for (p = 0; p < Phases; p++) begin
         set_screen(pick_dim(), pick_dim(), pick_origin(), pick_origin(), p[0]);
         steady = (p == Phases - 1);
         bursty = !steady && ($urandom_range(0, 3) != 0);
         for (n = 0; n < PhaseWords; n++) begin
            if (bursty && $urandom_range(0, 3) == 0)
               req_idle($urandom_range(1, 15));
            alpha = pick_alpha();
            send_pixel({alpha, 24'($urandom)}, $urandom,
                       pick_coord(cfg_x, cfg_width), pick_coord(cfg_y, cfg_height),
                       $urandom_range(0, 15) == 0);
         end
      end

      req_idle(1);
      do @(negedge clock); while (words_due != 0);
      repeat (TailCycles) @(negedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
